>>> sv/lap_pkg.sv
// Shared types, codes and reset values for the link action planner.
`timescale 1ns / 1ps

package lap_pkg;

  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_QUERY   = 2'd1,
    CMD_RESULT  = 2'd2,
    CMD_SERVER  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OUT_OK      = 2'd0,
    OUT_REFUSED = 2'd1,
    OUT_FAILED  = 2'd2,
    OUT_NONE    = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    CK_UNKNOWN   = 2'd0,
    CK_BROKEN    = 2'd1,
    CK_GCODE     = 2'd2,
    CK_SEND_INFO = 2'd3
  } command_kind_e;

  typedef enum logic [1:0] {
    ACT_SLEEP     = 2'd0,
    ACT_EVENT     = 2'd1,
    ACT_TELEMETRY = 2'd2,
    ACT_ACK       = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    EV_INFO     = 2'd0,
    EV_ACCEPTED = 2'd1,
    EV_REJECTED = 2'd2,
    EV_UNUSED   = 2'd3
  } event_e;

  typedef enum logic [1:0] {
    REG_BACKOFF_BASE = 2'd0,
    REG_BACKOFF_CAP  = 2'd1,
    REG_TELEM_PERIOD = 2'd2,
    REG_SILENCE_LIM  = 2'd3
  } reg_idx_e;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned MsW    = 16;
  localparam int unsigned TagW   = 32;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [MsW-1:0]   BackoffBaseRst = 16'd100;
  localparam logic [MsW-1:0]   BackoffCapRst  = 16'd60000;
  localparam logic [MsW-1:0]   TelemPeriodRst = 16'd4000;
  localparam logic [TimeW-1:0] SilenceLimRst  = 32'd10000;

endpackage

>>> sv/lap_req_if.sv
// Request channel of the link action planner: handshake and request fields.
`timescale 1ns / 1ps

interface lap_req_if
  import lap_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [TimeW-1:0]  now_ms;
  logic [1:0]        outcome;
  logic [1:0]        command_kind;
  logic [TagW-1:0]   command_tag;

  modport source (output valid, cmd, now_ms, outcome, command_kind, command_tag,
                  input ready);
  modport sink   (input valid, cmd, now_ms, outcome, command_kind, command_tag,
                  output ready);
endinterface

>>> sv/lap_rsp_if.sv
// Result channel of the link action planner: handshake and action fields.
`timescale 1ns / 1ps

interface lap_rsp_if
  import lap_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [1:0]      action_kind;
  logic [MsW-1:0]  sleep_ms;
  logic [1:0]      event_kind;
  logic            event_has_tag;
  logic [TagW-1:0] event_tag;

  modport source (output valid, action_kind, sleep_ms, event_kind, event_has_tag,
                  event_tag, input ready);
  modport sink   (input valid, action_kind, sleep_ms, event_kind, event_has_tag,
                  event_tag, output ready);
endinterface

>>> sv/link_action_planner.sv
// Link action planner: top level with state, action decision and result register.
`timescale 1ns / 1ps

// Every request (restart, query, action result, server command) produces exactly
// one action on the result channel, in the cycle after the request is taken. All
// state updates and the action decision are done in combinational logic
// (one 32-bit subtract and compare for the telemetry and silence checks, one
// doubling and clamp for the back-off), so a request is taken every cycle unless
// the result is stalled. The result register sits between the two channels: a
// new request is taken whenever the result register is empty or its contents
// leave in the same cycle, so a stalled result blocks further requests only until
// it is taken. Time differences are computed modulo 2^32. The configuration
// registers are plain write-only registers and should be written only while no
// request is in flight. After reset an untagged info event is planned and the
// registers hold their documented defaults (base 100, cap 60000, telemetry
// period 4000, silence limit 10000 ms).

module link_action_planner
  import lap_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  lap_req_if.sink            req_i,
  lap_rsp_if.source          rsp_o
);

  // configuration
  logic [MsW-1:0]   backoff_base_q, backoff_cap_q, telem_period_q;
  logic [TimeW-1:0] silence_lim_q;

  // planner state
  logic             pend_valid_q, pend_valid_d;
  logic [1:0]       pend_kind_q, pend_kind_d;
  logic             pend_has_tag_q, pend_has_tag_d;
  logic [TagW-1:0]  pend_tag_q, pend_tag_d;
  logic             telem_seen_q, telem_seen_d;
  logic [TimeW-1:0] telem_time_q, telem_time_d;
  logic             succ_seen_q, succ_seen_d;
  logic [TimeW-1:0] succ_time_q, succ_time_d;
  logic             backoff_valid_q, backoff_valid_d;
  logic [MsW-1:0]   backoff_q, backoff_d;
  logic             sleep_owed_q, sleep_owed_d;

  // result register
  logic             rsp_valid_q;
  logic [1:0]       act_q, act_d;
  logic [MsW-1:0]   slp_q, slp_d;
  logic [1:0]       evk_q, evk_d;
  logic             evh_q, evh_d;
  logic [TagW-1:0]  evt_q, evt_d;

  logic             req_fire;
  logic [TimeW-1:0] since_telem, silence;
  logic [MsW:0]     backoff_dbl;
  logic [MsW-1:0]   backoff_prev;

  // take a request when the result slot is free or drains this cycle
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;

  assign since_telem  = req_i.now_ms - telem_time_q;
  assign silence      = succ_seen_q ? (req_i.now_ms - succ_time_q) : '0;
  assign backoff_prev = backoff_valid_q ? backoff_q : (backoff_base_q >> 1);
  assign backoff_dbl  = {backoff_prev, 1'b0};

  always_comb begin
    pend_valid_d    = pend_valid_q;
    pend_kind_d     = pend_kind_q;
    pend_has_tag_d  = pend_has_tag_q;
    pend_tag_d      = pend_tag_q;
    telem_seen_d    = telem_seen_q;
    telem_time_d    = telem_time_q;
    succ_seen_d     = succ_seen_q;
    succ_time_d     = succ_time_q;
    backoff_valid_d = backoff_valid_q;
    backoff_d       = backoff_q;
    sleep_owed_d    = sleep_owed_q;
    act_d           = ACT_ACK;
    slp_d           = '0;
    evk_d           = EV_INFO;
    evh_d           = 1'b0;
    evt_d           = '0;

    case (cmd_e'(req_i.cmd))
      CMD_RESTART: begin
        pend_valid_d    = 1'b1;
        pend_kind_d     = EV_INFO;
        pend_has_tag_d  = 1'b0;
        pend_tag_d      = '0;
        telem_seen_d    = 1'b0;
        telem_time_d    = '0;
        backoff_valid_d = 1'b0;
        backoff_d       = '0;
        sleep_owed_d    = 1'b0;
      end
      CMD_QUERY: begin
        if (sleep_owed_q) begin
          sleep_owed_d = 1'b0;
          act_d        = ACT_SLEEP;
          slp_d        = backoff_q;
        end else if (pend_valid_q) begin
          act_d = ACT_EVENT;
          evk_d = pend_kind_q;
          evh_d = pend_has_tag_q;
          evt_d = pend_has_tag_q ? pend_tag_q : '0;
        end else if (telem_seen_q && (since_telem < TimeW'(telem_period_q))) begin
          act_d = ACT_SLEEP;
          // since < period, so the difference fits the period width
          slp_d = telem_period_q - since_telem[MsW-1:0];
        end else begin
          act_d = ACT_TELEMETRY;
        end
      end
      CMD_RESULT: begin
        case (outcome_e'(req_i.outcome))
          OUT_OK, OUT_REFUSED: begin
            succ_seen_d     = 1'b1;
            succ_time_d     = req_i.now_ms;
            sleep_owed_d    = 1'b0;
            backoff_valid_d = 1'b0;
            backoff_d       = '0;
            if (pend_valid_q) begin
              pend_valid_d   = 1'b0;
              pend_kind_d    = EV_INFO;
              pend_has_tag_d = 1'b0;
              pend_tag_d     = '0;
              telem_seen_d   = 1'b0;
              telem_time_d   = '0;
            end else begin
              telem_seen_d = 1'b1;
              telem_time_d = req_i.now_ms;
            end
          end
          OUT_FAILED: begin
            if ((silence >= silence_lim_q) && !pend_valid_q) begin
              pend_valid_d   = 1'b1;
              pend_kind_d    = EV_INFO;
              pend_has_tag_d = 1'b0;
              pend_tag_d     = '0;
              succ_seen_d    = 1'b0;
              succ_time_d    = '0;
            end
            if (backoff_dbl > (MsW+1)'(backoff_cap_q)) begin
              backoff_d = backoff_cap_q;
            end else begin
              backoff_d = backoff_dbl[MsW-1:0];
            end
            backoff_valid_d = 1'b1;
            sleep_owed_d    = 1'b1;
          end
          default: begin
            // unknown outcome: acknowledged, state kept
          end
        endcase
      end
      CMD_SERVER: begin
        pend_valid_d   = 1'b1;
        pend_kind_d    = (command_kind_e'(req_i.command_kind) == CK_SEND_INFO) ?
                         EV_INFO : EV_REJECTED;
        pend_has_tag_d = 1'b1;
        pend_tag_d     = req_i.command_tag;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backoff_base_q <= BackoffBaseRst;
      backoff_cap_q  <= BackoffCapRst;
      telem_period_q <= TelemPeriodRst;
      silence_lim_q  <= SilenceLimRst;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_BACKOFF_BASE: backoff_base_q <= cfg_data_i[MsW-1:0];
        REG_BACKOFF_CAP:  backoff_cap_q  <= cfg_data_i[MsW-1:0];
        REG_TELEM_PERIOD: telem_period_q <= cfg_data_i[MsW-1:0];
        REG_SILENCE_LIM:  silence_lim_q  <= cfg_data_i[TimeW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q    <= 1'b1;
      pend_kind_q     <= EV_INFO;
      pend_has_tag_q  <= 1'b0;
      pend_tag_q      <= '0;
      telem_seen_q    <= 1'b0;
      telem_time_q    <= '0;
      succ_seen_q     <= 1'b0;
      succ_time_q     <= '0;
      backoff_valid_q <= 1'b0;
      backoff_q       <= '0;
      sleep_owed_q    <= 1'b0;
      rsp_valid_q     <= 1'b0;
    end else begin
      if (req_fire) begin
        pend_valid_q    <= pend_valid_d;
        pend_kind_q     <= pend_kind_d;
        pend_has_tag_q  <= pend_has_tag_d;
        pend_tag_q      <= pend_tag_d;
        telem_seen_q    <= telem_seen_d;
        telem_time_q    <= telem_time_d;
        succ_seen_q     <= succ_seen_d;
        succ_time_q     <= succ_time_d;
        backoff_valid_q <= backoff_valid_d;
        backoff_q       <= backoff_d;
        sleep_owed_q    <= sleep_owed_d;
      end
      if (req_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each request
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      act_q <= act_d;
      slp_q <= slp_d;
      evk_q <= evk_d;
      evh_q <= evh_d;
      evt_q <= evt_d;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.action_kind   = act_q;
  assign rsp_o.sleep_ms      = slp_q;
  assign rsp_o.event_kind    = evk_q;
  assign rsp_o.event_has_tag = evh_q;
  assign rsp_o.event_tag     = evt_q;

  // an owed sleep always comes with a live back-off
  a_owed_has_backoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sleep_owed_q |-> backoff_valid_q)
    else $error("sleep owed without back-off");

  // untagged planned events carry a zero tag
  a_untagged_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_has_tag_q |-> (pend_tag_q == '0))
    else $error("untagged pending event holds a tag");

  // a waiting result holds off new requests
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_o.ready) |-> !req_i.ready)
    else $error("request taken while result stalled");

  // non-sleep actions report no sleep length
  a_sleep_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (act_q != ACT_SLEEP)) |-> (slp_q == '0))
    else $error("sleep length on non-sleep action");

  // event fields are clear unless an event is sent
  a_event_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (act_q != ACT_EVENT)) |-> (!evh_q && (evt_q == '0)))
    else $error("event fields set on non-event action");

endmodule
